// ===== rtl/tcsb_pkg.sv =====
// shared types and constants of the text console scroll buffer
`default_nettype none

package tcsb_pkg;

    localparam int CHAR_W    = 8;
    localparam int COLUMN_W  = 6;
    localparam int ROW_FLD_W = 5;

    localparam logic [CHAR_W-1:0] BLANK = 8'h20;

    typedef enum logic [1:0] {
        KIND_WRITE      = 2'd0,
        KIND_SET_CURSOR = 2'd1,
        KIND_CLEAR      = 2'd2,
        KIND_READ       = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [CHAR_W-1:0]    char_code;
        logic                 first_of_string;
        logic [COLUMN_W-1:0]  column;
        logic [ROW_FLD_W-1:0] row;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_value;
        logic              cursor_rejected;
        logic              scrolled;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_READ
    } t_state;

    typedef struct packed {
        logic take;
        logic fill_step;
        logic read_load;
    } t_dp_cmd;

    typedef struct packed {
        logic need_fill;
        logic need_read;
        logic fill_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/tcsb_chan_if.sv =====
// valid/ready channel interface carrying one item
`default_nettype none

interface tcsb_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/text_console_scroll_buffer.sv =====
// top level of the text console scroll buffer
//
// i_cmd carries one command item per handshake: write character, set cursor,
// clear screen or read cell. o_res returns exactly one result item for each
// command, in order.
// result path from accept to result valid:
//   set cursor, clear, out-of-range read, read of a blank row and a write
//   into a row that already holds characters: valid the cycle after accept
//   read of a row that holds characters: S_READ waits for the registered ram read
//   first write into a blank row: S_FILL sweeps that row with spaces and the
//   character at its column through the single ram write port
// one item is in flight at a time; short items sustain one per cycle while
// o_res is taken every cycle
// the screen is a ring of rows with a top-row pointer and one valid bit per
// row, so a scroll needs no row copy and clear screen drops all valid bits;
// a row without its valid bit reads as spaces
// reset (synchronous, active low) empties the screen, homes cursor and write
// position; no clearing pass is needed
// when o_res stalls, the result is held and i_cmd.ready drops until the
// pending result is taken
`default_nettype none

module text_console_scroll_buffer #(
    parameter int COLUMNS = 40,
    parameter int ROWS    = 24
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tcsb_chan_if.sink   i_cmd,
    tcsb_chan_if.source o_res
);
    import tcsb_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    t_state     w_state;
    logic       w_in_ready;
    logic       w_res_valid;
    t_out_item  w_res_item;

    // sequencer: handshake and multi-cycle steps
    tcsb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_state    (w_state)
    );

    // screen store and result register
    tcsb_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_cmd.payload),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_res_valid (w_res_valid),
        .o_res_item  (w_res_item),
        .i_res_ready (o_res.ready)
    );

    assign i_cmd.ready   = w_in_ready;
    assign o_res.valid   = w_res_valid;
    assign o_res.payload = w_res_item;

`ifndef SYNTHESIS
    // a row sweep always ends in a result
    a_fill_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state == S_FILL && w_status.fill_last) |=> o_res.valid)
        else $error("row fill finished without a result");

    // a ram read is delivered the cycle after its wait state
    a_read_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state == S_READ) |=> (o_res.valid && w_state == S_IDLE))
        else $error("cell read did not deliver a result");

    // a write into a blank row enters the sweep with no result pending
    a_fill_entry : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready && w_status.need_fill)
        |=> (w_state == S_FILL && !o_res.valid))
        else $error("blank row write did not start a clean sweep");
`endif

endmodule

`default_nettype wire

// ===== rtl/tcsb_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module tcsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/tcsb_ctrl.sv =====
// sequencer: item handshake, row fill sweep and read wait
`default_nettype none

module tcsb_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire tcsb_pkg::t_dp_status i_status,
    output tcsb_pkg::t_dp_cmd        o_cmd,
    output tcsb_pkg::t_state         o_state
);
    import tcsb_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_ready;
    logic   w_take;

    assign w_ready = (r_state == S_IDLE) && i_status.out_free;
    assign w_take  = i_in_valid && w_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_take && i_status.need_fill) begin
                    n_state = S_FILL;
                end else if (w_take && i_status.need_read) begin
                    n_state = S_READ;
                end
            end
            S_FILL: begin
                if (i_status.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready      = w_ready;
        o_cmd.take      = w_take;
        o_cmd.fill_step = (r_state == S_FILL);
        o_cmd.read_load = (r_state == S_READ);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

// ===== rtl/tcsb_datapath.sv =====
// screen store, cursor, write position, row mapping and result register
`default_nettype none

module tcsb_datapath #(
    parameter int COLUMNS = 40,
    parameter int ROWS    = 24
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire tcsb_pkg::t_in_item   i_item,
    input  wire tcsb_pkg::t_dp_cmd    i_cmd,
    output tcsb_pkg::t_dp_status      o_status,
    output logic                      o_res_valid,
    output tcsb_pkg::t_out_item       o_res_item,
    input  wire logic                 i_res_ready
);
    import tcsb_pkg::*;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = ROWS * (1 << COL_W);

    localparam logic [COLUMN_W:0]  COL_LIMIT = (COLUMN_W + 1)'(COLUMNS);
    localparam logic [ROW_FLD_W:0] ROW_LIMIT = (ROW_FLD_W + 1)'(ROWS);
    localparam logic [ROW_W:0]     ROW_WRAP  = (ROW_W + 1)'(ROWS);
    localparam logic [COL_W-1:0]   COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]   ROW_LAST  = ROW_W'(ROWS - 1);

    // architectural state
    logic [COL_W-1:0] r_cur_col;
    logic [ROW_W-1:0] r_cur_row;
    logic [COL_W-1:0] r_wr_col;
    logic [ROW_W-1:0] r_wr_row;
    logic [ROW_W-1:0] r_top;
    logic [ROWS-1:0]  r_row_valid;

    // fill sweep and result
    logic [COL_W-1:0]  r_fill_col;
    logic [ROW_W-1:0]  r_prow;
    logic [COL_W-1:0]  r_col;
    logic [CHAR_W-1:0] r_char;
    logic              r_scroll;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              w_in_range;
    logic              w_is_write;
    logic              w_is_read;
    logic [COL_W-1:0]  w_tgt_col;
    logic [ROW_W-1:0]  w_tgt_row;
    logic [COL_W-1:0]  w_lcol;
    logic [ROW_W-1:0]  w_lrow;
    logic [ROW_W:0]    w_sum;
    logic [ROW_W-1:0]  w_prow;
    logic              w_row_valid;
    logic              w_scroll;
    logic              w_fill_last;
    logic              w_immediate;
    t_out_item         w_imm;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [CHAR_W-1:0] w_wdata;
    logic [ADDR_W-1:0] w_raddr;
    logic [CHAR_W-1:0] w_rdata;

    assign w_in_range = ({1'b0, i_item.column} < COL_LIMIT) &&
                        ({1'b0, i_item.row} < ROW_LIMIT);
    assign w_is_write = (i_item.kind == KIND_WRITE);
    assign w_is_read  = (i_item.kind == KIND_READ);

    // a string start restarts at the cursor
    assign w_tgt_col = i_item.first_of_string ? r_cur_col : r_wr_col;
    assign w_tgt_row = i_item.first_of_string ? r_cur_row : r_wr_row;

    assign w_lcol = w_is_read ? i_item.column[COL_W-1:0] : w_tgt_col;
    assign w_lrow = w_is_read ? i_item.row[ROW_W-1:0]    : w_tgt_row;

    // logical row to physical row, modulo the row count
    assign w_sum  = {1'b0, w_lrow} + {1'b0, r_top};
    assign w_prow = (w_sum >= ROW_WRAP) ? ROW_W'(w_sum - ROW_WRAP) : w_sum[ROW_W-1:0];

    assign w_row_valid = r_row_valid[w_prow];
    assign w_scroll    = (w_tgt_col == COL_LAST) && (w_tgt_row == ROW_LAST);
    assign w_fill_last = (r_fill_col == COL_LAST);

    assign o_status.need_fill = w_is_write && !w_row_valid;
    assign o_status.need_read = w_is_read && w_in_range && w_row_valid;
    assign o_status.fill_last = w_fill_last;
    assign o_status.out_free  = !r_out_valid || i_res_ready;

    assign w_immediate = !o_status.need_fill && !o_status.need_read;

    always_comb begin
        w_imm = '0;
        case (i_item.kind)
            KIND_WRITE: begin
                w_imm.scrolled = w_scroll;
            end
            KIND_SET_CURSOR: begin
                w_imm.cursor_rejected = !w_in_range;
            end
            KIND_CLEAR: begin
                w_imm = '0;
            end
            KIND_READ: begin
                // in range here means a blank row
                w_imm.cursor_rejected = !w_in_range;
                w_imm.cell_value      = w_in_range ? BLANK : '0;
            end
            default: begin
                w_imm = '0;
            end
        endcase
    end

    // ram port selection
    assign w_we    = (i_cmd.take && w_is_write && w_row_valid) || i_cmd.fill_step;
    assign w_waddr = i_cmd.fill_step ? {r_prow, r_fill_col} : {w_prow, w_lcol};
    assign w_wdata = i_cmd.fill_step ? ((r_fill_col == r_col) ? r_char : BLANK)
                                     : i_item.char_code;
    assign w_raddr = {w_prow, w_lcol};

    tcsb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_wr_col    <= '0;
            r_wr_row    <= '0;
            r_top       <= '0;
            r_row_valid <= '0;
            r_fill_col  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_fill_col <= '0;
                case (i_item.kind)
                    KIND_WRITE: begin
                        r_row_valid[w_prow] <= 1'b1;
                        if (w_tgt_col == COL_LAST) begin
                            r_wr_col <= '0;
                            if (w_tgt_row != ROW_LAST) begin
                                r_wr_row <= w_tgt_row + 1'b1;
                            end else begin
                                r_wr_row <= ROW_LAST;
                            end
                        end else begin
                            r_wr_col <= w_tgt_col + 1'b1;
                            r_wr_row <= w_tgt_row;
                        end
                        // scroll: old top row becomes the blank bottom row
                        if (w_scroll) begin
                            r_row_valid[r_top] <= 1'b0;
                            r_top <= (r_top == ROW_LAST) ? '0 : r_top + 1'b1;
                        end
                    end
                    KIND_SET_CURSOR: begin
                        if (w_in_range) begin
                            r_cur_col <= i_item.column[COL_W-1:0];
                            r_cur_row <= i_item.row[ROW_W-1:0];
                        end
                    end
                    KIND_CLEAR: begin
                        r_row_valid <= '0;
                        r_cur_col   <= '0;
                        r_cur_row   <= '0;
                    end
                    KIND_READ: begin
                        // reads leave the screen state alone
                    end
                    default: begin
                    end
                endcase
            end else if (i_cmd.fill_step) begin
                r_fill_col <= r_fill_col + 1'b1;
            end

            if (i_cmd.take && w_immediate) begin
                r_out_valid <= 1'b1;
            end else if (i_cmd.fill_step && w_fill_last) begin
                r_out_valid <= 1'b1;
            end else if (i_cmd.read_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_prow   <= w_prow;
            r_col    <= w_lcol;
            r_char   <= i_item.char_code;
            r_scroll <= w_is_write && w_scroll;
            if (w_immediate) begin
                r_out_item <= w_imm;
            end
        end else if (i_cmd.fill_step && w_fill_last) begin
            r_out_item <= '{cell_value: '0, cursor_rejected: 1'b0, scrolled: r_scroll};
        end else if (i_cmd.read_load) begin
            r_out_item <= '{cell_value: w_rdata, cursor_rejected: 1'b0, scrolled: 1'b0};
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res_item  = r_out_item;

endmodule

`default_nettype wire

// ===== bench/console_screen_checker.sv =====
// channel monitor and screen predictor for the text console scroll buffer
`timescale 1ns / 100ps

module console_screen_checker #(
    parameter int COLUMNS = 40,
    parameter int ROWS    = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  logic                i_cmd_ready,
    input  tcsb_pkg::t_in_item  i_cmd_item,
    input  logic                i_res_valid,
    input  logic                i_res_ready,
    input  tcsb_pkg::t_out_item i_res_item,
    output int                  o_fail_count,
    output int                  o_pending
);
    import tcsb_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;

    // predicted screen contents, cursor and write position
    logic [CHAR_W-1:0] screen [CELLS];
    int unsigned       cur_col;
    int unsigned       cur_row;
    int unsigned       wr_pos;

    t_out_item results_due [$];
    int        fail_tally = 0;

    function automatic t_out_item apply_command(t_in_item c);
        t_out_item r;
        bit        on_screen;
        r = '0;
        on_screen = (c.column < COLUMNS) && (c.row < ROWS);
        case (c.kind)
            KIND_WRITE: begin
                if (c.first_of_string)
                    wr_pos = cur_row * COLUMNS + cur_col;
                if (wr_pos >= CELLS)
                    wr_pos = 0;
                screen[wr_pos] = c.char_code;
                wr_pos++;
                // ran off the last cell: shift every row up, blank the bottom one
                if (wr_pos >= CELLS) begin
                    for (int k = 0; k < CELLS - COLUMNS; k++)
                        screen[k] = screen[k + COLUMNS];
                    for (int k = CELLS - COLUMNS; k < CELLS; k++)
                        screen[k] = BLANK;
                    wr_pos = CELLS - COLUMNS;
                    r.scrolled = 1'b1;
                end
            end
            KIND_SET_CURSOR: begin
                if (on_screen) begin
                    cur_col = c.column;
                    cur_row = c.row;
                end else begin
                    r.cursor_rejected = 1'b1;
                end
            end
            KIND_CLEAR: begin
                // write position survives a clear, only the cursor goes home
                foreach (screen[k])
                    screen[k] = BLANK;
                cur_col = 0;
                cur_row = 0;
            end
            default: begin
                if (on_screen)
                    r.cell_value = screen[c.row * COLUMNS + c.column];
                else
                    r.cursor_rejected = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            fail_tally++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            foreach (screen[k])
                screen[k] = BLANK;
            cur_col = 0;
            cur_row = 0;
            wr_pos  = 0;
            results_due.delete();
        end else begin
            // results first: a result leaving now belongs to an earlier item
            if (i_res_valid && i_res_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, i_res_item);
                    fail_tally++;
                end else begin
                    want = results_due.pop_front();
                    check_field("cell_value", want.cell_value, i_res_item.cell_value);
                    check_field("cursor_rejected", want.cursor_rejected,
                                i_res_item.cursor_rejected);
                    check_field("scrolled", want.scrolled, i_res_item.scrolled);
                end
            end
            if (i_cmd_valid && i_cmd_ready)
                results_due.push_back(apply_command(i_cmd_item));
        end
        o_pending    <= results_due.size();
        o_fail_count <= fail_tally;
    end

endmodule

// ===== bench/tb.sv =====
// stimulus and verdict for the text console scroll buffer
`timescale 1ns / 100ps

module tb;
    import tcsb_pkg::*;

    localparam int COLUMNS      = 40;
    localparam int ROWS         = 24;
    localparam int RANDOM_ITEMS = 1600;
    // items at the end of the run with no idling on either side
    localparam int CALM_TAIL    = 200;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // set once the run enters its final stretch without gaps or stalls
    bit calm = 1'b0;

    int fail_count;
    int pending;

    tcsb_chan_if #(.t_payload(t_in_item))  cmd_if ();
    tcsb_chan_if #(.t_payload(t_out_item)) res_if ();

    text_console_scroll_buffer #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_cmd  (cmd_if.sink),
        .o_res  (res_if.source)
    );

    console_screen_checker #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) screen_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cmd_valid (cmd_if.valid),
        .i_cmd_ready (cmd_if.ready),
        .i_cmd_item  (cmd_if.payload),
        .i_res_valid (res_if.valid),
        .i_res_ready (res_if.ready),
        .i_res_item  (res_if.payload),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic t_in_item mk(t_kind k, int code, int first, int col, int row);
        t_in_item m;
        m.kind            = k;
        m.char_code       = code[7:0];
        m.first_of_string = first[0];
        m.column          = col[5:0];
        m.row             = row[4:0];
        return m;
    endfunction

    // offer one item, hold it until taken, then maybe leave a gap
    task automatic send_cmd(input t_in_item it);
        cmd_if.valid   <= 1'b1;
        cmd_if.payload <= it;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // stop offering items until every result is back
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // result side: random stall bursts, none in the tail
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    initial begin
        int n_sent;
        int pick;
        int len;
        int lead;
        int col;
        int row;
        bit paused_once;

        n_sent      = 0;
        paused_once = 1'b0;
        cmd_if.valid   <= 1'b0;
        cmd_if.payload <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        send_cmd(mk(KIND_READ, 0, 0, 0, 0));                    // untouched cell is blank
        send_cmd(mk(KIND_WRITE, 8'h00, 1, 0, 0));               // zero byte stored as is
        send_cmd(mk(KIND_WRITE, 8'hFF, 0, 63, 31));             // continues without restart
        send_cmd(mk(KIND_READ, 0, 0, 1, 0));
        send_cmd(mk(KIND_READ, 8'hFF, 1, 0, 0));
        send_cmd(mk(KIND_SET_CURSOR, 0, 0, COLUMNS - 1, ROWS - 1));
        send_cmd(mk(KIND_SET_CURSOR, 0, 0, COLUMNS, 0));        // column just off screen
        send_cmd(mk(KIND_SET_CURSOR, 0, 0, 0, ROWS));           // row just off screen
        send_cmd(mk(KIND_SET_CURSOR, 8'hFF, 1, 63, 31));        // both fields at their top
        send_cmd(mk(KIND_WRITE, "A", 1, 0, 0));                 // last cell, forces a scroll
        send_cmd(mk(KIND_READ, 0, 0, COLUMNS - 1, ROWS - 2));   // byte moved up one row
        send_cmd(mk(KIND_READ, 0, 0, COLUMNS - 1, ROWS - 1));   // bottom row blanked
        send_cmd(mk(KIND_WRITE, "B", 0, 0, 0));                 // resumes at bottom row start
        send_cmd(mk(KIND_READ, 0, 0, 0, ROWS - 1));
        send_cmd(mk(KIND_READ, 0, 0, COLUMNS, ROWS - 1));       // out-of-range reads
        send_cmd(mk(KIND_READ, 0, 0, 0, ROWS));
        send_cmd(mk(KIND_READ, 0, 0, 63, 31));
        send_cmd(mk(KIND_SET_CURSOR, 0, 0, 0, 0));              // zero is a valid position
        send_cmd(mk(KIND_CLEAR, 8'hFF, 1, 63, 31));
        send_cmd(mk(KIND_WRITE, "C", 0, 0, 0));                 // write position kept by clear
        send_cmd(mk(KIND_READ, 0, 0, 1, ROWS - 1));
        send_cmd(mk(KIND_WRITE, "D", 1, 0, 0));                 // restart at homed cursor
        send_cmd(mk(KIND_READ, 0, 0, 0, 0));
        wait_drained();

        // random part: mostly strings, with cursor moves, reads, clears and some noise
        while (n_sent < RANDOM_ITEMS) begin
            calm = (n_sent >= RANDOM_ITEMS - CALM_TAIL);
            if (!paused_once && n_sent >= RANDOM_ITEMS / 2) begin
                wait_drained();
                paused_once = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // a string, sometimes long enough to scroll more than once
                len  = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90)
                                                   : $urandom_range(1, 12);
                lead = ($urandom_range(0, 4) != 0);
                for (int k = 0; k < len; k++) begin
                    send_cmd(mk(KIND_WRITE, $urandom_range(0, 255), (k == 0) && lead,
                                $urandom_range(0, 63), $urandom_range(0, 31)));
                    n_sent++;
                end
            end else if (pick < 62) begin
                // cursor moves lean toward the bottom rows so strings reach the scroll
                if ($urandom_range(0, 4) == 0) begin
                    col = $urandom_range(0, 63);
                    row = $urandom_range(0, 31);
                end else begin
                    col = $urandom_range(0, COLUMNS - 1);
                    row = $urandom_range(0, 1) ? $urandom_range(ROWS - 3, ROWS - 1)
                                               : $urandom_range(0, ROWS - 1);
                end
                send_cmd(mk(KIND_SET_CURSOR, $urandom_range(0, 255),
                            $urandom_range(0, 1), col, row));
                n_sent++;
            end else if (pick < 92) begin
                if ($urandom_range(0, 6) == 0) begin
                    col = $urandom_range(0, 63);
                    row = $urandom_range(0, 31);
                end else begin
                    col = $urandom_range(0, COLUMNS - 1);
                    row = $urandom_range(0, ROWS - 1);
                end
                send_cmd(mk(KIND_READ, $urandom_range(0, 255), $urandom_range(0, 1),
                            col, row));
                n_sent++;
            end else if (pick < 94) begin
                send_cmd(mk(KIND_CLEAR, $urandom_range(0, 255), $urandom_range(0, 1),
                            $urandom_range(0, 63), $urandom_range(0, 31)));
                n_sent++;
            end else begin
                // noise: any kind, every field at random
                send_cmd(mk(t_kind'($urandom_range(0, 3)), $urandom_range(0, 255),
                            $urandom_range(0, 1), $urandom_range(0, 63),
                            $urandom_range(0, 31)));
                n_sent++;
            end
        end

        // let the last results out, then give a stray result time to show
        wait_drained();
        repeat (COLUMNS + 4) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
